[hw/rtl/sfr_pkg.sv]
`timescale 1ns / 1ps

package sfr_pkg;

   // Field widths of the header and result items.
   localparam int SEQ_WIDTH = 31;
   localparam int BYTE_COUNT_WIDTH = 16;
   localparam int FRAG_SIZE_WIDTH = 15;
   localparam int STATUS_WIDTH = 3;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAGMENT_SIZE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MESSAGE_MAX_SIZE = 1'd1;

   // Configuration reset values.
   localparam logic [FRAG_SIZE_WIDTH-1:0] FRAGMENT_SIZE_RESET = 15'd1300;
   localparam logic [BYTE_COUNT_WIDTH-1:0] MESSAGE_MAX_SIZE_RESET = 16'd16384;

   // Defaults for the top-level parameters.
   localparam int BUFFER_BYTES_DEFAULT = 32768;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Result status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_DELIVERED = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_STALE = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_MISSED = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_ILLEGAL = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] STATUS_PENDING = 3'd4;
   localparam logic [STATUS_WIDTH-1:0] STATUS_TOO_LARGE = 3'd5;

   // A classified header item as it travels from the front end to the back end.
   typedef struct packed {
      logic [SEQ_WIDTH-1:0] seq_number;
      logic is_fragment;
      logic [BYTE_COUNT_WIDTH-1:0] frag_start;
      logic [BYTE_COUNT_WIDTH-1:0] frag_len;
      logic [BYTE_COUNT_WIDTH-1:0] payload_bytes;
      logic len_negative;
      logic len_over_payload;
      logic len_full;
   } sfr_item_type;

endpackage

[hw/rtl/sfr_front.sv]
`timescale 1ns / 1ps

module sfr_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [sfr_pkg::SEQ_WIDTH-1:0] req_seq_number,
   input  logic req_is_fragment,
   input  logic signed [sfr_pkg::BYTE_COUNT_WIDTH-1:0] req_frag_start,
   input  logic signed [sfr_pkg::BYTE_COUNT_WIDTH-1:0] req_frag_len,
   input  logic [sfr_pkg::BYTE_COUNT_WIDTH-1:0] req_payload_bytes,
   input  logic csr_write_enable,
   input  logic [sfr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sfr_pkg::CSR_DATA_WIDTH-1:0] csr_write_data,
   output logic push_valid,
   input  logic push_ready,
   output sfr_pkg::sfr_item_type push_item,
   output logic [sfr_pkg::BYTE_COUNT_WIDTH-1:0] message_max_size
);

   logic [sfr_pkg::FRAG_SIZE_WIDTH-1:0] fragment_size_ff, fragment_size_in;
   logic [sfr_pkg::BYTE_COUNT_WIDTH-1:0] message_max_size_ff, message_max_size_in;
   logic stage_valid_ff, stage_valid_in;
   sfr_pkg::sfr_item_type stage_item_ff;
   sfr_pkg::sfr_item_type classified;
   logic accept;

   // Configuration register decode.
   always_comb begin
      fragment_size_in = fragment_size_ff;
      message_max_size_in = message_max_size_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            sfr_pkg::CSR_FRAGMENT_SIZE: begin
               fragment_size_in = csr_write_data[sfr_pkg::FRAG_SIZE_WIDTH-1:0];
            end
            sfr_pkg::CSR_MESSAGE_MAX_SIZE: begin
               message_max_size_in = csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Length checks that depend only on the header and the configuration.
   always_comb begin
      classified.seq_number = req_seq_number;
      classified.is_fragment = req_is_fragment;
      classified.frag_start = req_frag_start;
      classified.frag_len = req_frag_len;
      classified.payload_bytes = req_payload_bytes;
      classified.len_negative = req_frag_len[sfr_pkg::BYTE_COUNT_WIDTH-1];
      classified.len_over_payload = $unsigned(req_frag_len) > req_payload_bytes;
      classified.len_full = $unsigned(req_frag_len) == {1'b0, fragment_size_ff};
   end

   // One input stage; it drains into the queue whenever the queue has room.
   assign req_ready = !stage_valid_ff || push_ready;
   assign accept = req_valid && req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fragment_size_ff <= sfr_pkg::FRAGMENT_SIZE_RESET;
         message_max_size_ff <= sfr_pkg::MESSAGE_MAX_SIZE_RESET;
         stage_valid_ff <= 1'b0;
      end else begin
         fragment_size_ff <= fragment_size_in;
         message_max_size_ff <= message_max_size_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_item_ff <= classified;
      end
   end

   assign push_valid = stage_valid_ff;
   assign push_item = stage_item_ff;
   assign message_max_size = message_max_size_ff;

endmodule

[hw/rtl/sfr_queue.sv]
`timescale 1ns / 1ps

module sfr_queue #(
   parameter int QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  sfr_pkg::sfr_item_type push_item,
   output logic pop_valid,
   input  logic pop_ready,
   output sfr_pkg::sfr_item_type pop_item
);

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_SLOT = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(QUEUE_DEPTH);

   sfr_pkg::sfr_item_type storage_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = count_ff != FULL_COUNT;
   assign pop_valid = count_ff != '0;
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;
   assign pop_item = storage_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : PTR_WIDTH'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : PTR_WIDTH'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = COUNT_WIDTH'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = COUNT_WIDTH'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         storage_ff[wr_ptr_ff] <= push_item;
      end
   end

   // The fill count never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue fill count exceeds depth");

endmodule

[hw/rtl/sfr_back.sv]
`timescale 1ns / 1ps

module sfr_back #(
   parameter int BUFFER_BYTES = sfr_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic pop_valid,
   output logic pop_ready,
   input  sfr_pkg::sfr_item_type pop_item,
   input  logic [sfr_pkg::BYTE_COUNT_WIDTH-1:0] message_max_size,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_deliver,
   output logic [sfr_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic [sfr_pkg::SEQ_WIDTH-1:0] rsp_gap_count,
   output logic [sfr_pkg::BYTE_COUNT_WIDTH-1:0] rsp_message_length,
   output logic [sfr_pkg::SEQ_WIDTH-1:0] rsp_seq_out
);

   localparam int SUM_WIDTH = sfr_pkg::BYTE_COUNT_WIDTH + 1;
   localparam logic [SUM_WIDTH-1:0] BUFFER_LIMIT = SUM_WIDTH'(BUFFER_BYTES);

   logic [sfr_pkg::SEQ_WIDTH-1:0] last_seq_ff, last_seq_in;
   logic [sfr_pkg::SEQ_WIDTH-1:0] asm_seq_ff, asm_seq_in;
   logic [sfr_pkg::BYTE_COUNT_WIDTH-1:0] asm_bytes_ff, asm_bytes_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic deliver_ff, deliver_in;
   logic [sfr_pkg::STATUS_WIDTH-1:0] status_ff, status_in;
   logic [sfr_pkg::SEQ_WIDTH-1:0] gap_ff, gap_in;
   logic [sfr_pkg::BYTE_COUNT_WIDTH-1:0] length_ff, length_in;
   logic [sfr_pkg::SEQ_WIDTH-1:0] seq_out_ff, seq_out_in;

   logic fire, stale, missed, illegal;
   logic [sfr_pkg::BYTE_COUNT_WIDTH-1:0] base_bytes;
   logic [SUM_WIDTH-1:0] sum_wide;
   logic [sfr_pkg::BYTE_COUNT_WIDTH-1:0] sum_bytes;
   logic [sfr_pkg::SEQ_WIDTH-1:0] gap;

   // The head item is taken when the result register is free or being emptied.
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign fire = pop_valid && pop_ready;

   // Sequence and fragment checks against the current reassembly state.
   assign stale = pop_item.seq_number <= last_seq_ff;
   assign gap = sfr_pkg::SEQ_WIDTH'(pop_item.seq_number - last_seq_ff - 1'b1);
   assign base_bytes = (pop_item.seq_number != asm_seq_ff) ? '0 : asm_bytes_ff;
   assign missed = pop_item.frag_start[sfr_pkg::BYTE_COUNT_WIDTH-1]
                   || (pop_item.frag_start != base_bytes);
   assign sum_wide = {1'b0, base_bytes} + {1'b0, pop_item.frag_len};
   assign sum_bytes = sum_wide[sfr_pkg::BYTE_COUNT_WIDTH-1:0];
   assign illegal = pop_item.len_negative || pop_item.len_over_payload
                    || (sum_wide > BUFFER_LIMIT);

   // Result and state update for the head item.
   always_comb begin
      last_seq_in = last_seq_ff;
      asm_seq_in = asm_seq_ff;
      asm_bytes_in = asm_bytes_ff;
      deliver_in = 1'b0;
      status_in = sfr_pkg::STATUS_STALE;
      gap_in = '0;
      length_in = '0;
      seq_out_in = '0;
      if (!stale) begin
         gap_in = gap;
         if (!pop_item.is_fragment) begin
            deliver_in = 1'b1;
            status_in = sfr_pkg::STATUS_DELIVERED;
            length_in = pop_item.payload_bytes;
            seq_out_in = pop_item.seq_number;
            if (fire) begin
               last_seq_in = pop_item.seq_number;
            end
         end else begin
            if (fire) begin
               asm_seq_in = pop_item.seq_number;
               asm_bytes_in = base_bytes;
            end
            if (missed) begin
               status_in = sfr_pkg::STATUS_MISSED;
            end else if (illegal) begin
               status_in = sfr_pkg::STATUS_ILLEGAL;
            end else if (pop_item.len_full) begin
               status_in = sfr_pkg::STATUS_PENDING;
               if (fire) begin
                  asm_bytes_in = sum_bytes;
               end
            end else if (sum_bytes > message_max_size) begin
               status_in = sfr_pkg::STATUS_TOO_LARGE;
               if (fire) begin
                  asm_bytes_in = sum_bytes;
               end
            end else begin
               deliver_in = 1'b1;
               status_in = sfr_pkg::STATUS_DELIVERED;
               length_in = sum_bytes;
               seq_out_in = pop_item.seq_number;
               if (fire) begin
                  asm_bytes_in = '0;
                  last_seq_in = pop_item.seq_number;
               end
            end
         end
      end
   end

   // Result register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff <= '0;
         asm_seq_ff <= '0;
         asm_bytes_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_seq_ff <= last_seq_in;
         asm_seq_ff <= asm_seq_in;
         asm_bytes_ff <= asm_bytes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         deliver_ff <= deliver_in;
         status_ff <= status_in;
         gap_ff <= gap_in;
         length_ff <= length_in;
         seq_out_ff <= seq_out_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_deliver = deliver_ff;
   assign rsp_status = status_ff;
   assign rsp_gap_count = gap_ff;
   assign rsp_message_length = length_ff;
   assign rsp_seq_out = seq_out_ff;

   // A delivery always carries the delivered status and a nonzero sequence.
   a_deliver_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && deliver_ff |-> status_ff == sfr_pkg::STATUS_DELIVERED
                                     && seq_out_ff != '0)
      else $error("delivery without delivered status or sequence");

   // A stale result reports nothing else.
   a_stale_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == sfr_pkg::STATUS_STALE
         |-> !deliver_ff && gap_ff == '0 && seq_out_ff == '0 && length_ff == '0)
      else $error("stale result carries data");

   // The accepted sequence only moves forward.
   a_seq_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> last_seq_ff >= $past(last_seq_ff))
      else $error("accepted sequence moved backward");

   // The gathered byte count stays within the buffer.
   a_buffer_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, asm_bytes_ff} <= BUFFER_LIMIT)
      else $error("assembled bytes exceed buffer");

endmodule

[hw/rtl/sequenced_fragment_reassembly.sv]
`timescale 1ns / 1ps
// Path: each header item passes the input stage, the queue and the result register in turn,
// and waits in them while the result side stalls.
// Throughput: one item per cycle while rsp_ready is high; the back end updates its state as it takes each item.
// Reset: synchronous, active high; clears the sequence and reassembly state,
// empties the queue and result register, and restores the configuration defaults.

module sequenced_fragment_reassembly #(
   parameter int BUFFER_BYTES = sfr_pkg::BUFFER_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH = sfr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [sfr_pkg::SEQ_WIDTH-1:0] req_seq_number,
   input  logic req_is_fragment,
   input  logic signed [sfr_pkg::BYTE_COUNT_WIDTH-1:0] req_frag_start,
   input  logic signed [sfr_pkg::BYTE_COUNT_WIDTH-1:0] req_frag_len,
   input  logic [sfr_pkg::BYTE_COUNT_WIDTH-1:0] req_payload_bytes,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_deliver,
   output logic [sfr_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic [sfr_pkg::SEQ_WIDTH-1:0] rsp_gap_count,
   output logic [sfr_pkg::BYTE_COUNT_WIDTH-1:0] rsp_message_length,
   output logic [sfr_pkg::SEQ_WIDTH-1:0] rsp_seq_out,
   input  logic csr_write_enable,
   input  logic [sfr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sfr_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);

   logic push_valid, push_ready;
   logic pop_valid, pop_ready;
   sfr_pkg::sfr_item_type push_item, pop_item;
   logic [sfr_pkg::BYTE_COUNT_WIDTH-1:0] message_max_size;

   // Front end: configuration and header classification.
   sfr_front u_front (
      .clock (clock),
      .reset (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_seq_number (req_seq_number),
      .req_is_fragment (req_is_fragment),
      .req_frag_start (req_frag_start),
      .req_frag_len (req_frag_len),
      .req_payload_bytes (req_payload_bytes),
      .csr_write_enable (csr_write_enable),
      .csr_index (csr_index),
      .csr_write_data (csr_write_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item (push_item),
      .message_max_size (message_max_size)
   );

   // Queue between the front and back ends.
   sfr_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item (push_item),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item (pop_item)
   );

   // Back end: sequence tracking, reassembly and result register.
   sfr_back #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item (pop_item),
      .message_max_size (message_max_size),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_deliver (rsp_deliver),
      .rsp_status (rsp_status),
      .rsp_gap_count (rsp_gap_count),
      .rsp_message_length (rsp_message_length),
      .rsp_seq_out (rsp_seq_out)
   );

endmodule
